// ===== hw/rtl/cfnh_pkg.sv =====
`default_nettype none

package cfnh_pkg;

    // Hash mode codes
    localparam logic MODE_DJB2 = 1'b0;
    localparam logic MODE_FNV  = 1'b1;

    // Hash constants
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] FNV_SEED  = 32'd1268436527;
    localparam logic [31:0] DJB_SEED  = 32'd5381;
    localparam logic [31:0] DJB_MUL   = 32'd33;

    // Start value of a djb2 name after its first step, without the byte
    localparam logic [31:0] DJB_START = 32'(64'(DJB_MUL) * 64'(DJB_SEED));
    // FNV result for a name with no characters
    localparam logic [31:0] FNV_EMPTY = 32'(64'(FNV_PRIME) * 64'(FNV_SEED));

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // One finished name on its way to the output
    typedef struct packed {
        logic [31:0] hash;
        logic        need_final;
    } hash_item_t;

    // Fold A-Z to lower case, leave every other byte alone
    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // Multiply by the FNV prime modulo 2^32
    function automatic logic [31:0] fnv_mul(input logic [31:0] x);
        return x * FNV_PRIME;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfnh_core.sv =====
`default_nettype none

module cfnh_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   mode,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_byte,
    input  wire logic                   s_last,
    input  wire logic                   s_empty,
    output logic                        item_valid,
    input  wire logic                   item_ready,
    output cfnh_pkg::hash_item_t        item
);
    import cfnh_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        empty_reg;
    logic [31:0] running_hash_reg;
    logic        at_start_reg;

    logic        is_result;
    logic        fire;
    logic [7:0]  c;
    logic [31:0] base;
    logic [31:0] hash_next;

    // A beat leaves the input register when it yields nothing or the next stage takes it
    assign is_result  = empty_reg | last_reg;
    assign fire       = in_valid_reg & (~is_result | item_ready);
    assign s_ready    = ~in_valid_reg | fire;
    assign item_valid = in_valid_reg & is_result;

    // One hash step on the registered byte
    always_comb begin
        c         = fold_lower(byte_reg);
        base      = running_hash_reg;
        hash_next = running_hash_reg;
        if (empty_reg) begin
            hash_next = (mode == MODE_FNV) ? FNV_EMPTY : '0;
        end else if (mode == MODE_FNV) begin
            base      = at_start_reg ? FNV_SEED : running_hash_reg;
            hash_next = fnv_mul(base ^ {24'd0, c});
        end else begin
            base      = at_start_reg ? DJB_START : 32'(running_hash_reg * DJB_MUL);
            hash_next = base + {24'd0, c};
        end
    end

    assign item.hash       = hash_next;
    assign item.need_final = ~empty_reg & last_reg & (mode == MODE_FNV);

    // Control state and running hash
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            running_hash_reg <= '0;
            at_start_reg     <= 1'b1;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                running_hash_reg <= empty_reg ? '0 : hash_next;
                at_start_reg     <= is_result;
            end
        end
    end

    // Capture the incoming beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg  <= s_byte;
            last_reg  <= s_last;
            empty_reg <= s_empty;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfnh_final.sv =====
`default_nettype none

module cfnh_final (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire cfnh_pkg::hash_item_t   item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [31:0]                 m_hash
);
    import cfnh_pkg::*;

    logic        s2_valid_reg;
    hash_item_t  s2_item_reg;
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;

    logic        out_open;
    logic        s2_fire;
    logic [31:0] final_hash;

    // Advance when the slot ahead is empty or draining
    assign out_open   = ~out_valid_reg | m_ready;
    assign s2_fire    = s2_valid_reg & out_open;
    assign item_ready = ~s2_valid_reg | s2_fire;

    // Extra FNV step with a zero byte closes the name
    assign final_hash = s2_item_reg.need_final ? fnv_mul(s2_item_reg.hash) : s2_item_reg.hash;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_ready) begin
                s2_valid_reg <= item_valid;
            end
            if (out_open) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && item_ready) begin
            s2_item_reg <= item;
        end
        if (s2_fire) begin
            out_hash_reg <= final_hash;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_hash  = out_hash_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/case_folded_name_hash.sv =====
// A closing beat's hash passes the input, final-stage and output registers to m_tvalid. One
// name byte per cycle, set by the running-hash loop (one constant multiply), unless m_tready
// stalls a closing beat. The closing FNV multiply sits in its own stage after the hash loop.
// Reset: synchronous, active low; clears all valid flags, selects djb2, starts a new name.
`default_nettype none

module case_folded_name_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data,   // [0] hash_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] name_byte
    input  wire logic        s_tlast,
    input  wire logic [0:0]  s_tuser,    // [0] empty_name
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // [31:0] hash_value
);
    import cfnh_pkg::*;

    logic       mode_reg;
    logic       item_valid;
    logic       item_ready;
    hash_item_t item;

    // Mode register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_DJB2;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data[0];
        end
    end

    cfnh_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_byte     (s_tdata),
        .s_last     (s_tlast),
        .s_empty    (s_tuser[0]),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    cfnh_final u_final (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_hash     (m_tdata)
    );

    // Reset empties the pipe and opens the input
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

    // A finished name waiting on the final stage is not dropped
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !item_ready |=> item_valid)
        else $error("finished name lost while stalled");

endmodule

`default_nettype wire
